// ----- hw/rtl/lrupr_pkg.sv -----
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by lrupr_ram and lru_page_replacement.
package lrupr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned FAULT_W = 16;
  localparam int unsigned CFG_W   = 5;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_FRAMES    = 16;
  localparam int unsigned DEF_PAGE_BITS = 16;

  // Lower frame count limit and reset value of the configuration register
  localparam int unsigned MIN_FRAMES = 3;
  localparam logic [CFG_W-1:0] FRAMES_RST = CFG_W'(4);

  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_t;

endpackage

// ----- hw/rtl/lrupr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on lrupr_pkg for its parameter defaults; no types used.
module lrupr_ram import lrupr_pkg::*; #(
  parameter int unsigned WIDTH = PAGE_W,
  parameter int unsigned DEPTH = DEF_FRAMES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lru_page_replacement.sv -----
// Top level of the LRU page replacement block: control sequencer, valid bits,
// fault counter and result registers. Depends on lrupr_pkg and lrupr_ram.
//
// Usage
// - Input: raise start with in_page_number and in_last_ref; the transfer takes
//   place at a clock edge where start is high and busy is low.
// - Result: one result per reference, shown for exactly one cycle with
//   out_valid high. The receiver cannot stall, so take it in that cycle.
// - Configuration: cfg_data carries frames_in_use; a transfer completes when
//   cfg_valid and cfg_ready are both high. Write it only while busy is low.
//   Values below 3 act as 3, values above FRAMES act as FRAMES (n below).
// - Timing: page numbers and ranks live in one RAM with a registered read.
//   A reference takes a scan pass (n reads, one frame a cycle) and a rank
//   update pass (n read-modify-writes): the result is registered as the
//   last write-back happens, and busy drops in that same cycle; no new
//   reference is taken while one is in flight.
// - Reset: valid bits and fault count clear at once; frames_in_use returns
//   to 4. Page entries are only read behind a valid bit, so no clearing pass.
// - A reference with in_last_ref set empties the table and clears the fault
//   count once its result is formed.
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int unsigned FRAMES    = DEF_FRAMES,
  parameter int unsigned PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // reference channel
  input  logic               start,
  output logic               busy,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic               in_last_ref,
  // result channel
  output logic               out_valid,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_frame_slot,
  output logic               out_evicted_valid,
  output logic [PAGE_W-1:0]  out_evicted_page,
  output logic [FAULT_W-1:0] out_fault_count,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam int unsigned RANK_W = $clog2(FRAMES);
  localparam int unsigned ENT_W  = PAGE_BITS + RANK_W;
  localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(FRAMES - 1);

  // ---------------------------------------------------------------- state
  lrupr_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     frames_r, frames_nxt;
  logic [FRAMES-1:0]    valid_r, valid_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;
  logic                 chk_r, chk_nxt;       // read data on rdata this cycle
  logic                 out_valid_r, out_valid_nxt;

  // payload / working registers (no reset)
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     addr_r, addr_nxt;     // next RAM read to issue
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic [RANK_W-1:0]    hit_rank_r, hit_rank_nxt;
  logic                 empty_r, empty_nxt;
  logic [IDX_W-1:0]     empty_slot_r, empty_slot_nxt;
  logic [IDX_W-1:0]     best_slot_r, best_slot_nxt;
  logic [RANK_W-1:0]    best_rank_r, best_rank_nxt;
  logic [PAGE_BITS-1:0] best_page_r, best_page_nxt;

  logic                 out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                 out_evict_r, out_evict_nxt;
  logic [PAGE_W-1:0]    out_epage_r, out_epage_nxt;
  logic [FAULT_W-1:0]   out_fault_r, out_fault_nxt;

  // ---------------------------------------------------------------- RAM
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;

  lrupr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- helpers
  logic                 accept;
  logic [CMP_W-1:0]     cfg_ext, n_clamp;
  logic [PAGE_W+PAGE_BITS-1:0] in_page_ext;
  logic                 rd_v;
  logic [PAGE_BITS-1:0] rd_page;
  logic [RANK_W-1:0]    rd_rank;
  logic                 evict;
  logic [IDX_W-1:0]     slot;
  logic [SLOT_W+IDX_W-1:0]     slot_ext;
  logic [PAGE_W+PAGE_BITS-1:0] epage_ext;
  logic [FAULT_W-1:0]   fault_new;
  logic                 age;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  // Clamp the frame count into MIN_FRAMES..FRAMES
  assign cfg_ext = CMP_W'(frames_r);
  always_comb begin
    if (cfg_ext < CMP_W'(MIN_FRAMES)) begin
      n_clamp = CMP_W'(MIN_FRAMES);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      n_clamp = CMP_W'(FRAMES);
    end else begin
      n_clamp = cfg_ext;
    end
  end

  assign in_page_ext = {{PAGE_BITS{1'b0}}, in_page_number};

  // Split the entry on the read port; an empty frame reads as rank zero
  assign rd_v    = valid_r[chk_idx_r];
  assign rd_page = ram_rdata[ENT_W-1:RANK_W];
  assign rd_rank = rd_v ? ram_rdata[RANK_W-1:0] : '0;

  // Outcome of the scan pass
  assign evict = ~found_r & ~empty_r;
  always_comb begin
    if (found_r) begin
      slot = hit_slot_r;
    end else if (empty_r) begin
      slot = empty_slot_r;
    end else begin
      slot = best_slot_r;
    end
  end
  assign slot_ext  = {{SLOT_W{1'b0}}, slot};
  assign epage_ext = {{PAGE_W{1'b0}}, best_page_r};
  assign fault_new = (found_r || fault_r == FAULT_MAX) ? fault_r : fault_r + 1'b1;

  // Age a valid frame younger than the hit frame, or any valid frame below the top rank on a fault
  assign age = rd_v && (found_r ? (rd_rank < hit_rank_r) : (rd_rank < MAX_RANK));

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt      = state_r;
    frames_nxt     = frames_r;
    valid_nxt      = valid_r;
    fault_nxt      = fault_r;
    chk_nxt        = 1'b0;
    out_valid_nxt  = 1'b0;
    n_nxt          = n_r;
    page_nxt       = page_r;
    last_nxt       = last_r;
    addr_nxt       = addr_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    hit_slot_nxt   = hit_slot_r;
    hit_rank_nxt   = hit_rank_r;
    empty_nxt      = empty_r;
    empty_slot_nxt = empty_slot_r;
    best_slot_nxt  = best_slot_r;
    best_rank_nxt  = best_rank_r;
    best_page_nxt  = best_page_r;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_evict_nxt  = out_evict_r;
    out_epage_nxt  = out_epage_r;
    out_fault_nxt  = out_fault_r;
    ram_re         = 1'b0;
    ram_raddr      = addr_r[IDX_W-1:0];
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = ram_rdata;

    if (cfg_valid && cfg_ready) begin
      frames_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt     = CNT_W'(n_clamp);
          page_nxt  = in_page_ext[PAGE_BITS-1:0];
          last_nxt  = in_last_ref;
          addr_nxt  = '0;
          found_nxt = 1'b0;
          empty_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; judge the entry that came back
        ram_re = (addr_r < n_r);
        if (ram_re) begin
          addr_nxt    = addr_r + 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = addr_r[IDX_W-1:0];
        end
        if (chk_r) begin
          if (!found_r && rd_v && rd_page == page_r) begin
            found_nxt    = 1'b1;
            hit_slot_nxt = chk_idx_r;
            hit_rank_nxt = rd_rank;
          end
          if (!empty_r && !rd_v) begin
            empty_nxt      = 1'b1;
            empty_slot_nxt = chk_idx_r;
          end
          // Oldest frame, lowest index on a tie
          if (chk_idx_r == '0 || rd_rank > best_rank_r) begin
            best_slot_nxt = chk_idx_r;
            best_rank_nxt = rd_rank;
            best_page_nxt = rd_page;
          end
        end
        if (!ram_re) begin
          addr_nxt  = '0;
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        // Read entry i while writing back entry i-1
        ram_re = (addr_r < n_r);
        if (ram_re) begin
          addr_nxt    = addr_r + 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = addr_r[IDX_W-1:0];
        end
        if (chk_r) begin
          ram_we = 1'b1;
          if (chk_idx_r == slot) begin
            ram_wdata = {page_r, {RANK_W{1'b0}}};
          end else if (age) begin
            ram_wdata = {rd_page, rd_rank + 1'b1};
          end
        end
        if (!ram_re) begin
          // Last write-back happens at this edge; present the result
          out_valid_nxt = 1'b1;
          out_hit_nxt   = found_r;
          out_slot_nxt  = slot_ext[SLOT_W-1:0];
          out_evict_nxt = evict;
          out_epage_nxt = evict ? epage_ext[PAGE_W-1:0] : '0;
          out_fault_nxt = fault_new;
          if (last_r) begin
            valid_nxt = '0;
            fault_nxt = '0;
          end else begin
            valid_nxt[slot] = 1'b1;
            fault_nxt       = fault_new;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frames_r    <= FRAMES_RST;
      valid_r     <= '0;
      fault_r     <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frames_r    <= frames_nxt;
      valid_r     <= valid_nxt;
      fault_r     <= fault_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    page_r       <= page_nxt;
    last_r       <= last_nxt;
    addr_r       <= addr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_r      <= found_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_rank_r   <= hit_rank_nxt;
    empty_r      <= empty_nxt;
    empty_slot_r <= empty_slot_nxt;
    best_slot_r  <= best_slot_nxt;
    best_rank_r  <= best_rank_nxt;
    best_page_r  <= best_page_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_evict_r  <= out_evict_nxt;
    out_epage_r  <= out_epage_nxt;
    out_fault_r  <= out_fault_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_slot_r;
  assign out_evicted_valid = out_evict_r;
  assign out_evicted_page  = out_epage_r;
  assign out_fault_count   = out_fault_r;

`ifndef SYNTH
  // Read and write-back of the same entry must never collide
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  // A result is shown only once the sequencer is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // An accepted reference keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("reference accepted but sequencer not started");

  // Writes only happen during the update pass
  a_write_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_UPDATE))
    else $error("RAM write outside the update pass");
`endif

endmodule

// ----- tb/tb_lru_page_replacement.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement: a small tracker class
// predicts each reference result and checks the block's output against it.
// Depends on lrupr_pkg and the lru_page_replacement RTL only.
module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_REFS    = 200;
  localparam int unsigned RING_REFS     = 40;
  localparam int unsigned POOL_MAX      = 20;
  localparam int unsigned TAIL_CYCLES   = 2 * DEF_FRAMES + 8;
  // Allow ample margin over the slowest clean run
  localparam longint unsigned TIMEOUT_NS = 64'd2_000_000;

  // One result of a page reference, laid out as the result ports
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } ref_result_t;

  // Tracks the page table alongside the block and holds the results still due.
  class lru_ref_tracker;
    logic [PAGE_W-1:0]  frame_page [DEF_FRAMES];
    bit                 frame_valid[DEF_FRAMES];
    int unsigned        frame_age  [DEF_FRAMES];
    logic [FAULT_W-1:0] fault_total;
    logic [CFG_W-1:0]   frames_cfg;
    ref_result_t        results_due[$];
    int unsigned        errors;

    function new();
      frames_cfg = FRAMES_RST;
      errors     = 0;
      clear_frames();
    endfunction

    // Empty every frame and restart the fault count (reset and last reference)
    function void clear_frames();
      for (int unsigned i = 0; i < DEF_FRAMES; i++) begin
        frame_page[i]  = '0;
        frame_valid[i] = 1'b0;
        frame_age[i]   = 0;
      end
      fault_total = '0;
    endfunction

    function void set_frames(input logic [CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    // Frames taking part in replacement, clamped to MIN_FRAMES..DEF_FRAMES
    function int unsigned active_frames();
      if (frames_cfg < MIN_FRAMES) return MIN_FRAMES;
      if (frames_cfg > DEF_FRAMES) return DEF_FRAMES;
      return frames_cfg;
    endfunction

    // Age valid active frames younger than limit; ages saturate at the top rank
    function void age_frames(input int unsigned n, input int unsigned limit);
      for (int unsigned i = 0; i < n; i++)
        if (frame_valid[i] && frame_age[i] < limit && frame_age[i] < DEF_FRAMES - 1)
          frame_age[i]++;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // Work out the result of an accepted reference and queue it
    function void note_reference(input logic [PAGE_W-1:0] page, input logic last);
      int unsigned n;
      int unsigned slot;
      bit          found;
      bit          got_empty;
      ref_result_t want;
      n         = active_frames();
      slot      = 0;
      found     = 1'b0;
      got_empty = 1'b0;
      want      = '0;
      for (int unsigned i = 0; i < n; i++)
        if (!found && frame_valid[i] && frame_page[i] == page) begin
          slot  = i;
          found = 1'b1;
        end
      if (found) begin
        age_frames(n, frame_age[slot]);
        frame_age[slot] = 0;
      end else begin
        for (int unsigned i = 0; i < n; i++)
          if (!got_empty && !frame_valid[i]) begin
            slot      = i;
            got_empty = 1'b1;
          end
        if (!got_empty) begin
          // Oldest active frame; ties go to the lowest index
          slot = 0;
          for (int unsigned i = 1; i < n; i++)
            if (frame_age[i] > frame_age[slot]) slot = i;
          want.evicted_valid = 1'b1;
          want.evicted_page  = frame_page[slot];
          frame_valid[slot]  = 1'b0;
        end
        age_frames(n, DEF_FRAMES);
        frame_page[slot]  = page;
        frame_valid[slot] = 1'b1;
        frame_age[slot]   = 0;
        if (fault_total != FAULT_MAX) fault_total++;
      end
      want.hit         = found;
      want.frame_slot  = SLOT_W'(slot);
      want.fault_count = fault_total;
      results_due.push_back(want);
      if (last) clear_frames();
    endfunction

    function void compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Check one result from the block against the oldest one due
    function void check_result(input ref_result_t got);
      ref_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = results_due.pop_front();
      compare_field("hit",           want.hit,           got.hit);
      compare_field("frame_slot",    want.frame_slot,    got.frame_slot);
      compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
      compare_field("evicted_page",  want.evicted_page,  got.evicted_page);
      compare_field("fault_count",   want.fault_count,   got.fault_count);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [PAGE_W-1:0]  in_page_number;
  logic               in_last_ref;
  logic               out_valid;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_frame_slot;
  logic               out_evicted_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [FAULT_W-1:0] out_fault_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;

  lru_ref_tracker     book;
  logic [PAGE_W-1:0]  hot_pages[POOL_MAX];

  lru_page_replacement uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .in_last_ref       (in_last_ref),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Present one reference and hold it until the block takes the transfer.
  // Start is left high: the caller either presents the next reference in the
  // same step or lowers start through idle_start or wait_idle.
  task automatic send_ref(input logic [PAGE_W-1:0] page, input logic last);
    start          <= 1'b1;
    in_page_number <= page;
    in_last_ref    <= last;
    do @(posedge clk); while (busy);
    book.note_reference(page, last);
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_start(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every result due has arrived and the block is free again.
  // Every reference yields a result, so no extra settling time is needed here.
  task automatic wait_idle();
    start <= 1'b0;
    while (book.pending() != 0 || busy) @(posedge clk);
  endtask

  // Write frames_in_use; call only with the block idle and never twice in a row
  task automatic write_frames(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_frames(value);
  endtask

  // Favour the clamp limits, otherwise any register value
  function automatic logic [CFG_W-1:0] pick_frames_cfg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(MIN_FRAMES);
      2:       return CFG_W'(DEF_FRAMES);
      3:       return '1;
      default: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    endcase
  endfunction

  // Mostly a small working set so hits and LRU evictions dominate; the rest
  // are near misses (one bit off a hot page) and fully random pages
  function automatic logic [PAGE_W-1:0] pick_page(input int unsigned pool_size);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return hot_pages[$urandom_range(0, pool_size - 1)];
    if (roll < 88)
      return hot_pages[$urandom_range(0, pool_size - 1)] ^
             (PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
    return PAGE_W'($urandom);
  endfunction

  // Take each result in the one cycle it is shown; values are read before the
  // block's own updates at this edge, so nothing depends on event order
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      book.check_result('{out_hit, out_frame_slot, out_evicted_valid,
                          out_evicted_page, out_fault_count});
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout waiting on the block", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned       n;
    int unsigned       pool_size;
    int unsigned       idle_pct;
    logic [PAGE_W-1:0] ring_base;

    book           = new();
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_page_number <= '0;
    in_last_ref    <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width of four frames: fill, hit, then evict the oldest twice,
    // using both page extremes; the last reference empties the table
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0003, 1'b1);

    // Zero clamps up to three frames
    wait_idle();
    write_frames('0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h1234, 1'b0);

    // All ones clamps down to sixteen; the table is kept, so frames 3 and 4
    // fill while frames 0..2 carry their old ages
    wait_idle();
    write_frames('1);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h5555, 1'b0);

    // Shrink to three: frames 3 and 4 go stale but keep page and age; the same
    // page now lands in a low frame as well
    wait_idle();
    write_frames(CFG_W'(MIN_FRAMES));
    send_ref(16'h0F0F, 1'b0);
    send_ref(16'hAAAA, 1'b0);

    // Grow again: duplicate page resolves to the lowest frame, ages may tie
    wait_idle();
    write_frames(CFG_W'(DEF_FRAMES));
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'hF0F0, 1'b0);
    send_ref(16'h5555, 1'b1);

    // Steady faulting: cycle four pages through three frames so that, once the
    // three frames are full, every reference evicts the oldest frame
    wait_idle();
    write_frames(CFG_W'(MIN_FRAMES));
    ring_base = PAGE_W'($urandom);
    for (int unsigned k = 0; k < RING_REFS; k++)
      send_ref(ring_base ^ PAGE_W'((k % 4) << (PAGE_W - 2)), k == RING_REFS - 1);

    // Random phases: new width and working set each time, table kept across
    // width changes unless a last reference clears it; the final phase runs
    // without idling
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_frames(pick_frames_cfg());
      n         = book.active_frames();
      pool_size = n + $urandom_range(0, 4);
      for (int unsigned k = 0; k < pool_size; k++) hot_pages[k] = PAGE_W'($urandom);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (ph == PHASES - 1) idle_pct = 0;
      for (int unsigned k = 0; k < PHASE_REFS; k++) begin
        send_ref(pick_page(pool_size), $urandom_range(0, 49) == 0);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          idle_start($urandom_range(1, 18));
      end
    end

    // Drain, then watch a little longer for stray results
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.pending() != 0)
      $display("%0t: %0d results never arrived", $time, book.pending());
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- lru_page_replacement.f -----
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_ram.sv
hw/rtl/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
